// ----- hdl/nnmp_pkg.sv -----
`default_nettype none
package nnmp_pkg;

    // parse modes
    typedef logic [3:0] t_mode;
    localparam t_mode MODE_IDLE    = 4'd0;
    localparam t_mode MODE_PLUS    = 4'd1;
    localparam t_mode MODE_MINUS   = 4'd2;
    localparam t_mode MODE_MOD     = 4'd3;
    localparam t_mode MODE_SHARPED = 4'd4;
    localparam t_mode MODE_DOTTED  = 4'd5;
    localparam t_mode MODE_SLASH   = 4'd6;
    localparam t_mode MODE_DASH    = 4'd7;
    localparam t_mode MODE_SKIP    = 4'd8;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_NONE = 2'd0;
    localparam t_cmd CMD_S    = 2'd1;
    localparam t_cmd CMD_V    = 2'd2;
    localparam t_cmd CMD_T    = 2'd3;

    localparam logic [1:0] KIND_NOTE = 2'd0;
    localparam logic [1:0] KIND_PROG = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_NOTE  = 2'd1;
    localparam logic [1:0] ERR_SHARP = 2'd2;
    localparam logic [1:0] ERR_VALUE = 2'd3;

    localparam logic [1:0] REG_VOLUME = 2'd0;
    localparam logic [1:0] REG_CHAN   = 2'd1;
    localparam logic [1:0] REG_BEAT   = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_V     = 8'h56;

    localparam logic [24:0] ACC_MAX = 25'h1FF_FFFF;
    localparam logic [16:0] NUM_MAX = 17'h1_FFFF;
    localparam logic [19:0] DUR_MAX = 20'hF_FFFF;
    localparam logic [7:0]  NOTE_REST = 8'd128;
    localparam logic [7:0]  NOTE_TOP  = 8'd127;
    localparam logic [6:0]  VAL7_MAX  = 7'd127;
    localparam logic [3:0]  OCT_START = 4'd4;
    localparam logic [3:0]  OCT_TOP   = 4'd15;
    localparam logic [3:0]  OFF_E     = 4'd4;
    localparam logic [3:0]  OFF_B     = 4'd11;

    function automatic logic [3:0] scale_off(input logic [2:0] idx);
        logic [3:0] r;
        unique case (idx)
            3'd0:    r = 4'd0;
            3'd1:    r = 4'd2;
            3'd2:    r = 4'd4;
            3'd3:    r = 4'd5;
            3'd4:    r = 4'd7;
            3'd5:    r = 4'd9;
            3'd6:    r = 4'd11;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/nnmp_div.sv -----
`default_nettype none
module nnmp_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 17
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DEN_W-1:0] r_den, n_den;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W:0]   trial;

    // restoring division, one quotient bit a cycle
    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_den  = r_den;
        n_rem  = r_rem;
        n_quo  = r_quo;
        trial  = {r_rem, r_quo[NUM_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W);
            n_den  = i_den;
            n_rem  = '0;
            n_quo  = i_num;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = DEN_W'(trial - {1'b0, r_den});
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DEN_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_den <= n_den;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start) else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without a run");
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("busy after done");

endmodule
`default_nettype wire

// ----- hdl/numbered_notation_to_midi_parser.sv -----
`default_nettype none
// numbered-notation score parser, MIDI events out
// input channel: one score character per word on i_ch, i_valid / o_stall.
// output channel: one event per word (note, program change, end, error),
//   o_valid / i_stall, held in an output register until taken.
// most characters are taken without a stall; a word, if any, is on the output the next cycle.
// a comma that ends a note stalls the input while the dash count times the beat
//   goes through one multiplier and is registered before the final add.
// a comma that runs an S command starts the restoring divider; o_stall stays
//   high until its quotient is loaded as the new beat.
// o_stall is also high while a word waits in the output register and the
//   receiver stalls, since the next character may need that register.
// config writes (index 0 volume, 1 channel, 2 beat) load at once; the user must
//   make them only while the block is idle, the block itself does not enforce it.
// synchronous reset: octave 4, volume 100, beat 8000, channel 0, no word out.
// after an error or an end-of-score word every character is dropped until
//   reset.
module numbered_notation_to_midi_parser #(
    parameter int FRAC_BITS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_ch,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_status_byte,
    output logic [7:0]       o_data_one,
    output logic [6:0]       o_data_two,
    output logic [19:0]      o_duration_ms,
    output logic [1:0]       o_error_code,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [19:0] i_cfg_data
);
    import nnmp_pkg::*;

    localparam int NUM_W = 16 + FRAC_BITS;
    localparam logic [NUM_W-1:0] DIVIDEND = NUM_W'(60000) << FRAC_BITS;

    localparam logic [1:0] SEQ_IDLE = 2'd0;
    localparam logic [1:0] SEQ_MUL  = 2'd1;
    localparam logic [1:0] SEQ_DIV  = 2'd2;

    logic [1:0]  r_seq, n_seq;
    t_mode       r_mode, n_mode;
    logic [3:0]  r_oct, n_oct;
    logic [7:0]  r_note, n_note;
    logic [23:0] r_beat, n_beat;
    logic [24:0] r_acc, n_acc;
    logic [6:0]  r_vol, n_vol;
    logic [16:0] r_num, n_num;
    t_cmd        r_cmd, n_cmd;
    logic        r_halt, n_halt;
    logic [6:0]  r_vel, n_vel;
    logic [16:0] r_dash, n_dash;
    logic [3:0]  r_soff, n_soff;
    logic        r_cmt, n_cmt;
    logic        r_cdig, n_cdig;
    logic [3:0]  r_chan, n_chan;
    logic [40:0] r_prod, n_prod;

    logic        r_o_valid, n_o_valid;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_st, n_st;
    logic [7:0]  r_d1, n_d1;
    logic [6:0]  r_d2, n_d2;
    logic [19:0] r_dur, n_dur;
    logic [1:0]  r_err, n_err;

    logic        accept;
    logic        div_start, div_done;
    logic [NUM_W-1:0] div_quo;
    logic        is_digit, is_note;
    logic [20:0] num_next;
    logic [8:0]  pitch;
    logic [25:0] dot_sum;
    logic [41:0] dur_sum;
    logic [24:0] dur_sat;
    logic [24:0] dur_ms;

    assign accept   = i_valid && !o_stall;
    assign is_digit = i_ch >= CH_ZERO && i_ch <= CH_NINE;
    assign is_note  = i_ch >= CH_ZERO && i_ch <= CH_SEVEN;
    assign num_next = 21'(r_num) * 21'd10 + 21'(i_ch - CH_ZERO);
    assign dot_sum  = {1'b0, r_acc} + {2'b0, r_acc[24:1]};
    assign dur_sum  = {17'b0, r_acc} + {1'b0, r_prod};
    assign dur_sat  = (dur_sum > {17'b0, ACC_MAX}) ? ACC_MAX : dur_sum[24:0];
    assign dur_ms   = dur_sat >> FRAC_BITS;

    always_comb begin
        n_seq = r_seq; n_mode = r_mode; n_oct = r_oct; n_note = r_note;
        n_beat = r_beat; n_acc = r_acc; n_vol = r_vol; n_num = r_num;
        n_cmd = r_cmd; n_halt = r_halt; n_vel = r_vel; n_dash = r_dash;
        n_soff = r_soff; n_cmt = r_cmt; n_cdig = r_cdig; n_chan = r_chan;
        n_prod = r_prod;
        n_o_valid = r_o_valid && i_stall;
        n_kind = r_kind; n_st = r_st; n_d1 = r_d1; n_d2 = r_d2;
        n_dur = r_dur; n_err = r_err;
        div_start = 1'b0;
        pitch = '0;

        priority if (r_seq == SEQ_MUL) begin
            n_seq = SEQ_IDLE;
            n_o_valid = 1'b1;
            n_kind = KIND_NOTE; n_st = {4'h9, r_chan}; n_d1 = r_note; n_d2 = r_vel;
            n_dur = (dur_ms > {5'b0, DUR_MAX}) ? DUR_MAX : dur_ms[19:0];
            n_err = ERR_NONE;
        end else if (r_seq == SEQ_DIV) begin
            if (div_done) begin
                n_beat = 24'(div_quo);
                n_seq = SEQ_IDLE;
            end
        end else if (accept && !r_halt) begin
            // end, error and program-change words made here go straight to the output register
            n_st = '0; n_d1 = '0; n_d2 = '0; n_dur = '0; n_err = ERR_NONE;
            n_kind = KIND_END;
            if (r_cmt) begin
                if (i_ch == CH_NL) n_cmt = 1'b0;
            end else if (r_cmd != CMD_NONE) begin
                if (i_ch == CH_DOLLAR) begin
                    n_halt = 1'b1; n_o_valid = 1'b1;
                end else if (r_cdig && is_digit) begin
                    n_num = (num_next > 21'(NUM_MAX)) ? NUM_MAX : num_next[16:0];
                end else begin
                    n_cdig = 1'b0;
                    if (i_ch == CH_COMMA) begin
                        n_cmd = CMD_NONE;
                        if (r_num == '0) begin
                            n_halt = 1'b1; n_o_valid = 1'b1;
                            n_kind = KIND_ERR; n_err = ERR_VALUE;
                        end else begin
                            unique case (r_cmd)
                                CMD_S: begin
                                    div_start = 1'b1;
                                    n_seq = SEQ_DIV;
                                end
                                CMD_V: n_vol = (r_num > 17'(VAL7_MAX)) ? VAL7_MAX
                                                                      : r_num[6:0];
                                default: begin
                                    n_o_valid = 1'b1; n_kind = KIND_PROG;
                                    n_st = {4'hC, r_chan};
                                    n_d1 = (r_num > 17'(VAL7_MAX)) ? {1'b0, VAL7_MAX}
                                                                   : {1'b0, r_num[6:0]};
                                end
                            endcase
                        end
                    end
                end
            end else if (r_mode == MODE_SKIP) begin
                if (i_ch == CH_COMMA) begin
                    n_prod = 41'(r_dash) * 41'(r_beat); n_seq = SEQ_MUL;
                    n_mode = MODE_IDLE;
                end else if (i_ch == CH_DOLLAR) begin
                    n_halt = 1'b1; n_o_valid = 1'b1;
                end
            end else if (i_ch == CH_DOLLAR || i_ch == CH_NUL) begin
                n_halt = 1'b1; n_o_valid = 1'b1;
            end else if (i_ch == CH_SPACE || i_ch == CH_TAB || i_ch == CH_NL) begin
                n_cmt = r_cmt;
            end else if (i_ch == CH_AT) begin
                n_cmt = 1'b1;
            end else if (i_ch == CH_S || i_ch == CH_V || i_ch == CH_T) begin
                n_cmd = (i_ch == CH_S) ? CMD_S : ((i_ch == CH_V) ? CMD_V : CMD_T);
                n_num = '0;
                n_cdig = 1'b1;
            end else if (r_mode == MODE_IDLE || r_mode == MODE_PLUS
                         || r_mode == MODE_MINUS) begin
                if (r_mode == MODE_IDLE) begin
                    n_oct = OCT_START; n_acc = {1'b0, r_beat}; n_vel = r_vol;
                    n_dash = '0;
                end
                if (i_ch == CH_PLUS && r_mode != MODE_MINUS) begin
                    if (n_oct < OCT_TOP) n_oct = n_oct + 1'b1;
                    n_mode = MODE_PLUS;
                end else if (i_ch == CH_MINUS) begin
                    if (n_oct != '0) n_oct = n_oct - 1'b1;
                    n_mode = MODE_MINUS;
                end else if (is_note) begin
                    if (i_ch == CH_ZERO) begin
                        n_note = NOTE_REST; n_mode = MODE_SKIP;
                    end else begin
                        n_soff = scale_off(3'(i_ch - CH_ONE));
                        pitch = 9'(n_oct) * 9'd12 + 9'(n_soff);
                        n_note = (pitch > 9'(NOTE_TOP)) ? NOTE_TOP : pitch[7:0];
                        n_mode = MODE_MOD;
                    end
                end else begin
                    n_halt = 1'b1; n_o_valid = 1'b1;
                    n_kind = KIND_ERR; n_err = ERR_NOTE;
                end
            end else if (i_ch == CH_COMMA) begin
                n_prod = 41'(r_dash) * 41'(r_beat); n_seq = SEQ_MUL; n_mode = MODE_IDLE;
            end else if (i_ch == CH_HASH && r_mode == MODE_MOD) begin
                if (r_soff == OFF_E || r_soff == OFF_B) begin
                    n_halt = 1'b1; n_o_valid = 1'b1;
                    n_kind = KIND_ERR; n_err = ERR_SHARP;
                end else begin
                    if (r_note < NOTE_TOP) n_note = r_note + 1'b1;
                    n_mode = MODE_SHARPED;
                end
            end else if (i_ch == CH_DOT
                         && (r_mode == MODE_MOD || r_mode == MODE_SHARPED)) begin
                n_acc = (dot_sum > {1'b0, ACC_MAX}) ? ACC_MAX : dot_sum[24:0];
                n_mode = MODE_DOTTED;
            end else if (i_ch == CH_SLASH && (r_mode == MODE_MOD
                         || r_mode == MODE_SHARPED || r_mode == MODE_SLASH)) begin
                n_acc = r_acc >> 1;
                n_mode = MODE_SLASH;
            end else if (i_ch == CH_MINUS) begin
                if (r_dash < NUM_MAX) n_dash = r_dash + 1'b1;
                n_mode = MODE_DASH;
            end else begin
                n_mode = MODE_SKIP;
            end
        end

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_VOLUME: n_vol = i_cfg_data[6:0];
                REG_CHAN:   n_chan = i_cfg_data[3:0];
                REG_BEAT:   n_beat = {4'b0, i_cfg_data};
                default:    n_chan = n_chan;
            endcase
        end
    end

    nnmp_div #(
        .NUM_W(NUM_W),
        .DEN_W(17)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (DIVIDEND),
        .i_den  (r_num),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= SEQ_IDLE; r_mode <= MODE_IDLE; r_oct <= OCT_START;
            r_note <= '0; r_beat <= 24'd8000; r_acc <= '0; r_vol <= 7'd100;
            r_num <= '0; r_cmd <= CMD_NONE; r_halt <= 1'b0; r_vel <= '0;
            r_dash <= '0; r_soff <= '0; r_cmt <= 1'b0; r_cdig <= 1'b0;
            r_chan <= '0; r_o_valid <= 1'b0;
        end else begin
            r_seq <= n_seq; r_mode <= n_mode; r_oct <= n_oct; r_note <= n_note;
            r_beat <= n_beat; r_acc <= n_acc; r_vol <= n_vol; r_num <= n_num;
            r_cmd <= n_cmd; r_halt <= n_halt; r_vel <= n_vel; r_dash <= n_dash;
            r_soff <= n_soff; r_cmt <= n_cmt; r_cdig <= n_cdig; r_chan <= n_chan;
            r_o_valid <= n_o_valid;
        end
        r_prod <= n_prod;
        r_kind <= n_kind; r_st <= n_st; r_d1 <= n_d1; r_d2 <= n_d2;
        r_dur <= n_dur; r_err <= n_err;
    end

    assign o_stall       = (r_seq != SEQ_IDLE) || (r_o_valid && i_stall);
    assign o_valid       = r_o_valid;
    assign o_kind        = r_kind;
    assign o_status_byte = r_st;
    assign o_data_one    = r_d1;
    assign o_data_two    = r_d2;
    assign o_duration_ms = r_dur;
    assign o_error_code  = r_err;

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq != SEQ_IDLE |-> o_stall) else $error("input taken while busy");
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_seq == SEQ_DIV) else $error("divider result unclaimed");
    a_note_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_NOTE |-> o_status_byte[7:4] == 4'h9)
        else $error("note word with bad status");

endmodule
`default_nettype wire

// ----- dv/nnmp_checker.sv -----
`timescale 1ns / 1ps
module nnmp_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [7:0]  i_ch,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_status_byte,
    input  wire logic [7:0]  i_data_one,
    input  wire logic [6:0]  i_data_two,
    input  wire logic [19:0] i_duration_ms,
    input  wire logic [1:0]  i_error_code,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [19:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);
    import nnmp_pkg::*;

    localparam int FRAC = 4;
    localparam logic [3:0] STEP_OFFSET [7] = '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11};

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  status;
        logic [7:0]  d1;
        logic [6:0]  d2;
        logic [19:0] dur;
        logic [1:0]  err;
    } t_event;

    t_event midi_events[$];

    logic [6:0]  vol_cfg;
    logic [3:0]  chan;
    t_mode       mode;
    logic [3:0]  oct;
    logic [7:0]  note_num;
    logic [23:0] beat_len;
    logic [24:0] dur_acc;
    logic [6:0]  cur_vol;
    logic [6:0]  vel;
    logic [16:0] num_acc;
    logic [16:0] dashes;
    logic [3:0]  offs;
    t_cmd        cmd;
    logic        halted;
    logic        in_comment;
    logic        cmd_digits;
    int          fails;

    function automatic void post(logic [1:0] kind, logic [7:0] st, logic [7:0] d1,
                                 logic [6:0] d2, logic [19:0] dur, logic [1:0] err);
        t_event e;
        e = '{kind: kind, status: st, d1: d1, d2: d2, dur: dur, err: err};
        midi_events.push_back(e);
    endfunction

    function automatic void halt_with(logic [1:0] kind, logic [1:0] err);
        halted = 1'b1;
        post(kind, 8'd0, 8'd0, 7'd0, 20'd0, err);
    endfunction

    function automatic void emit_note();
        longint t;
        t = longint'(dur_acc) + longint'(dashes) * longint'(beat_len);
        if (t > longint'(ACC_MAX)) t = longint'(ACC_MAX);
        t = t >> FRAC;
        if (t > longint'(DUR_MAX)) t = longint'(DUR_MAX);
        mode = MODE_IDLE;
        post(KIND_NOTE, 8'h90 | {4'd0, chan}, note_num, vel, t[19:0], ERR_NONE);
    endfunction

    function automatic void take_digit(logic [7:0] c);
        int v;
        if (c == CH_ZERO) begin
            note_num = NOTE_REST;
            mode = MODE_SKIP;
        end else begin
            offs = STEP_OFFSET[c - CH_ONE];
            v = int'(oct) * 12 + int'(offs);
            note_num = (v > 127) ? NOTE_TOP : v[7:0];
            mode = MODE_MOD;
        end
    endfunction

    function automatic void run_command();
        int n;
        t_cmd k;
        n = int'(num_acc);
        k = cmd;
        cmd = CMD_NONE;
        if (n == 0) begin
            halt_with(KIND_ERR, ERR_VALUE);
        end else if (k == CMD_S) begin
            beat_len = 24'((longint'(60000) << FRAC) / n);
        end else if (k == CMD_V) begin
            cur_vol = (n > 127) ? VAL7_MAX : n[6:0];
        end else begin
            post(KIND_PROG, 8'hC0 | {4'd0, chan}, (n > 127) ? 8'd127 : n[7:0],
                 7'd0, 20'd0, ERR_NONE);
        end
    endfunction

    function automatic void parse_char(logic [7:0] c);
        logic is_digit;
        logic is_note;
        longint t;
        int acc;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_note = (c >= CH_ZERO) && (c <= CH_SEVEN);
        if (halted) return;
        if (in_comment) begin
            if (c == CH_NL) in_comment = 1'b0;
            return;
        end
        if (cmd != CMD_NONE) begin
            if (c == CH_DOLLAR) begin
                halt_with(KIND_END, ERR_NONE);
                return;
            end
            if (cmd_digits && is_digit) begin
                acc = int'(num_acc) * 10 + int'(c - CH_ZERO);
                num_acc = (acc > int'(NUM_MAX)) ? NUM_MAX : acc[16:0];
                return;
            end
            cmd_digits = 1'b0;
            if (c == CH_COMMA) run_command();
            return;
        end
        if (mode == MODE_SKIP) begin
            if (c == CH_COMMA) emit_note();
            else if (c == CH_DOLLAR) halt_with(KIND_END, ERR_NONE);
            return;
        end
        if (c == CH_DOLLAR || c == CH_NUL) begin
            halt_with(KIND_END, ERR_NONE);
            return;
        end
        if (c == CH_SPACE || c == CH_TAB || c == CH_NL) return;
        if (c == CH_AT) begin
            in_comment = 1'b1;
            return;
        end
        if (c == CH_S || c == CH_V || c == CH_T) begin
            cmd = (c == CH_S) ? CMD_S : ((c == CH_V) ? CMD_V : CMD_T);
            num_acc = '0;
            cmd_digits = 1'b1;
            return;
        end
        if (mode == MODE_IDLE) begin
            oct = OCT_START;
            dur_acc = {1'b0, beat_len};
            vel = cur_vol;
            dashes = '0;
            if (c == CH_PLUS) begin
                oct = oct + 4'd1;
                mode = MODE_PLUS;
            end else if (c == CH_MINUS) begin
                oct = oct - 4'd1;
                mode = MODE_MINUS;
            end else if (is_note) begin
                take_digit(c);
            end else begin
                halt_with(KIND_ERR, ERR_NOTE);
            end
            return;
        end
        if (mode == MODE_PLUS || mode == MODE_MINUS) begin
            if (c == CH_PLUS && mode == MODE_PLUS) begin
                if (oct < OCT_TOP) oct = oct + 4'd1;
            end else if (c == CH_MINUS) begin
                if (oct > 4'd0) oct = oct - 4'd1;
                mode = MODE_MINUS;
            end else if (is_note) begin
                take_digit(c);
            end else begin
                halt_with(KIND_ERR, ERR_NOTE);
            end
            return;
        end
        // modifiers after the digit
        if (c == CH_COMMA) begin
            emit_note();
        end else if (c == CH_HASH && mode == MODE_MOD) begin
            if (offs == OFF_E || offs == OFF_B) begin
                halt_with(KIND_ERR, ERR_SHARP);
            end else begin
                if (note_num < NOTE_TOP) note_num = note_num + 8'd1;
                mode = MODE_SHARPED;
            end
        end else if (c == CH_DOT && (mode == MODE_MOD || mode == MODE_SHARPED)) begin
            t = longint'(dur_acc) + longint'(dur_acc >> 1);
            dur_acc = (t > longint'(ACC_MAX)) ? ACC_MAX : t[24:0];
            mode = MODE_DOTTED;
        end else if (c == CH_SLASH && (mode == MODE_MOD || mode == MODE_SHARPED ||
                                       mode == MODE_SLASH)) begin
            dur_acc = dur_acc >> 1;
            mode = MODE_SLASH;
        end else if (c == CH_MINUS) begin
            if (dashes < NUM_MAX) dashes = dashes + 17'd1;
            mode = MODE_DASH;
        end else begin
            mode = MODE_SKIP;
        end
    endfunction

    always @(posedge i_clk) begin
        t_event e;
        if (!i_rst_n) begin
            vol_cfg = 7'd100;
            chan = 4'd0;
            mode = MODE_IDLE;
            oct = OCT_START;
            note_num = '0;
            beat_len = 24'd8000;
            dur_acc = '0;
            cur_vol = 7'd100;
            vel = '0;
            num_acc = '0;
            dashes = '0;
            offs = '0;
            cmd = CMD_NONE;
            halted = 1'b0;
            in_comment = 1'b0;
            cmd_digits = 1'b0;
            midi_events.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_VOLUME: begin
                        vol_cfg = i_cfg_data[6:0];
                        cur_vol = vol_cfg;
                    end
                    REG_CHAN: chan = i_cfg_data[3:0];
                    REG_BEAT: beat_len = {4'd0, i_cfg_data};
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) parse_char(i_ch);
            if (i_out_valid && !i_out_stall) begin
                if (midi_events.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected word kind %0d data_one %0d", $time,
                             i_kind, i_data_one);
                end else begin
                    e = midi_events.pop_front();
                    if (e.kind !== i_kind || e.status !== i_status_byte ||
                        e.d1 !== i_data_one || e.d2 !== i_data_two ||
                        e.dur !== i_duration_ms || e.err !== i_error_code) begin
                        fails++;
                        $display("%0t: mismatch exp kind %0d st %h d1 %0d d2 %0d dur %0d err %0d",
                                 $time, e.kind, e.status, e.d1, e.d2, e.dur, e.err);
                        $display("%0t:          act kind %0d st %h d1 %0d d2 %0d dur %0d err %0d",
                                 $time, i_kind, i_status_byte, i_data_one, i_data_two,
                                 i_duration_ms, i_error_code);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= midi_events.size();
    end

endmodule

// ----- dv/tb_numbered_notation_to_midi_parser.sv -----
`timescale 1ns / 1ps
module tb_numbered_notation_to_midi_parser;
    import nnmp_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_ch;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [7:0]  o_status_byte;
    logic [7:0]  o_data_one;
    logic [6:0]  o_data_two;
    logic [19:0] o_duration_ms;
    logic [1:0]  o_error_code;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [19:0] i_cfg_data;
    int          fail_count;
    int          pending;
    int          tx_idle;
    int          rx_idle;
    int          chars_sent;
    int          quiet_cycles;

    numbered_notation_to_midi_parser u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_ch(i_ch),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_kind(o_kind), .o_status_byte(o_status_byte), .o_data_one(o_data_one),
        .o_data_two(o_data_two), .o_duration_ms(o_duration_ms),
        .o_error_code(o_error_code),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    nnmp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_ch(i_ch),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_kind(o_kind), .i_status_byte(o_status_byte), .i_data_one(o_data_one),
        .i_data_two(o_data_two), .i_duration_ms(o_duration_ms),
        .i_error_code(o_error_code),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_idle);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // valid is left high after a word; the next call decides it once
    task automatic put_char(input logic [7:0] c);
        while ($urandom_range(99) < tx_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch <= c;
        do @(posedge i_clk); while (o_stall);
        chars_sent++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endtask

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CH_COMMA || b == CH_DOLLAR);
        return b;
    endfunction

    task automatic junk_tail();
        repeat ($urandom_range(0, 4)) put_char(junk_byte());
    endtask

    // blanks and comments where a significant character is expected
    task automatic pad();
        int r;
        logic [7:0] b;
        r = $urandom_range(9);
        if (r == 0) begin
            case ($urandom_range(2))
                0: put_char(CH_SPACE);
                1: put_char(CH_TAB);
                default: put_char(CH_NL);
            endcase
        end else if (r == 1) begin
            put_char(CH_AT);
            repeat ($urandom_range(0, 5)) begin
                do b = 8'($urandom); while (b == CH_NL);
                put_char(b);
            end
            put_char(CH_NL);
        end
    endtask

    task automatic send_command();
        int r;
        int n;
        r = $urandom_range(2);
        put_char(r == 0 ? CH_S : (r == 1 ? CH_V : CH_T));
        if ($urandom_range(4) == 0) put_char(CH_ZERO);
        if ($urandom_range(19) == 0) put_text("999999");
        else begin
            n = (r == 0) ? $urandom_range(1, 400) : $urandom_range(1, 300);
            put_text($sformatf("%0d", n));
        end
        case ($urandom_range(3))
            0: put_text(".5");
            1: junk_tail();
            default: ;
        endcase
        put_char(CH_COMMA);
    endtask

    task automatic send_note();
        int r;
        int digit_idx;
        int n_plus;
        int n_minus;
        int n_dash;
        pad();
        if ($urandom_range(9) == 0) send_command();
        r = $urandom_range(9);
        n_plus = (r < 6) ? 0 : ((r < 9) ? $urandom_range(1, 3) : $urandom_range(8, 16));
        r = $urandom_range(9);
        n_minus = (r < 6) ? 0 : ((r < 9) ? $urandom_range(1, 3) : $urandom_range(5, 16));
        repeat (n_plus) put_char(CH_PLUS);
        repeat (n_minus) put_char(CH_MINUS);
        pad();
        digit_idx = $urandom_range(0, 7);
        put_char(CH_ZERO + 8'(digit_idx));
        if (digit_idx == 0) begin
            junk_tail();
            put_char(CH_COMMA);
            return;
        end
        if (digit_idx != 3 && digit_idx != 7 && $urandom_range(2) == 0) put_char(CH_HASH);
        pad();
        case ($urandom_range(2))
            0: put_char(CH_DOT);
            1: repeat ($urandom_range(1, 4)) put_char(CH_SLASH);
            default: ;
        endcase
        r = $urandom_range(19);
        n_dash = (r < 10) ? 0 : ((r < 19) ? $urandom_range(1, 3) : $urandom_range(30, 45));
        repeat (n_dash) put_char(CH_MINUS);
        pad();
        if ($urandom_range(5) == 0) begin
            case ($urandom_range(3))
                0: put_char("x");
                1: put_char(CH_NINE);
                2: put_char(8'hFE);
                default: put_char("!");
            endcase
            junk_tail();
        end
        put_char(CH_COMMA);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [19:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input int target, input logic [6:0] vol,
                             input logic [3:0] chan, input logic [19:0] beat);
        wait_idle();
        cfg_write(REG_VOLUME, {13'd0, vol});
        cfg_write(REG_CHAN, {16'd0, chan});
        cfg_write(REG_BEAT, beat);
        i_cfg_we <= 1'b0;
        while (chars_sent < target) begin
            if ($urandom_range(5) == 0) send_command();
            else send_note();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_ch <= 8'd0;
        i_stall <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_VOLUME;
        i_cfg_data <= '0;
        tx_idle = 0;
        rx_idle = 0;
        chars_sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: saturating commands, slowest tempo, octave and note limits, rest, comment
        put_text("T300,V200,S1,++++++++++++6#.--,");
        put_char(CH_ZERO);
        put_char(8'hFF);
        put_char(CH_NUL);
        put_char(CH_COMMA);
        put_text("@ $\n--------2#//-,");

        tx_idle = 17;
        rx_idle = 54;
        run_phase(400, 7'd1, 4'd15, 20'd16);
        tx_idle = 54;
        rx_idle = 17;
        run_phase(780, 7'd127, 4'd0, 20'd960000);
        tx_idle = 0;
        rx_idle = 0;
        run_phase(1150, 7'($urandom_range(1, 127)), 4'($urandom), 20'($urandom_range(16, 20000)));

        // one halting case per run, then text that must be ignored
        case ($urandom_range(6))
            0: put_char(CH_DOLLAR);
            1: put_char(CH_NUL);
            2: put_char("x");
            3: put_text("3#");
            4: put_text("V0,");
            5: put_text("+7#");
            default: put_text("S00,");
        endcase
        put_text("1,T5,$");

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
